// ===== hw/rtl/psqs_pkg.sv =====
// Package: shared types, codes and defaults for the pipeline stage queue scoreboard.
package psqs_pkg;

  localparam int NUM_QUEUES      = 5;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int MAX_SOURCES_DEF = 3;
  localparam int PC_BITS_DEF     = 32;
  localparam int MARK_CAP        = 8;

  typedef enum logic [2:0] {
    FUNC_ENQUEUE = 3'd0,
    FUNC_DEQUEUE = 3'd1,
    FUNC_CHECK   = 3'd2,
    FUNC_EXECUTE = 3'd3,
    FUNC_MEMORY  = 3'd4
  } func_t;

  localparam logic [2:0] STG_FETCH     = 3'd0;
  localparam logic [2:0] STG_DECODE    = 3'd1;
  localparam logic [2:0] STG_EXECUTE   = 3'd2;
  localparam logic [2:0] STG_MEMORY    = 3'd3;
  localparam logic [2:0] STG_WRITEBACK = 3'd4;

  localparam logic [1:0] KIND_LOAD  = 2'd2;
  localparam logic [1:0] KIND_STORE = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam logic [1:0] CFG_EXECUTE_WIDTH = 2'd0;
  localparam logic [1:0] CFG_MEMORY_WIDTH  = 2'd1;

  typedef struct packed {
    logic [2:0]  func;
    logic [2:0]  stage;
    logic [31:0] pc;
    logic [1:0]  kind;
    logic        executed_in;
    logic        memorized_in;
    logic [1:0]  source_count;
    logic [31:0] source_pc_a;
    logic [31:0] source_pc_b;
    logic [31:0] source_pc_c;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        ready_res;
    logic [3:0]  marked_count;
    logic [31:0] out_pc;
    logic [1:0]  out_kind;
    logic        out_executed;
    logic        out_memorized;
    logic [1:0]  out_source_count;
    logic [31:0] out_source_a;
    logic [31:0] out_source_b;
    logic [31:0] out_source_c;
  } out_item_t;

endpackage

// ===== hw/rtl/psqs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module psqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write one word, register one read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/pipeline_stage_queues_scoreboard_unit.sv =====
// Top level: five stage queues of instruction records with a dependency scoreboard.
//
// Input channel in_valid / in_stall / in_data carries one command per transfer:
// enqueue, dequeue, check decode head, execute pass or memory pass. Each command
// gives exactly one result on out_valid / out_stall / out_data.
// Configuration writes on cfg_valid / cfg_ready / cfg_index / cfg_data set the
// execute and memory pass widths; cfg_ready is always high.
// All records live in one RAM with a registered read port; a small sequencer
// walks it one entry at a time through a shared slot address adder.
// A pass visits the entries of its queue; a check scans the execute and memory
// queues for each source of the decode head. One command is in the block at a
// time; in_stall stays high from transfer until the result has been taken.
// A stalled result holds in its register until out_stall falls.
// Synchronous reset empties every queue and sets both pass widths to 1.
module pipeline_stage_queues_scoreboard_unit
  import psqs_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int MAX_SOURCES = MAX_SOURCES_DEF,
  parameter int PC_BITS     = PC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [3:0] cfg_data
);

  localparam int SLOTS  = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AW     = $clog2(SLOTS);
  localparam int HW     = $clog2(QUEUE_DEPTH);
  localparam int FW     = $clog2(QUEUE_DEPTH + 1);
  localparam int WB     = (PC_BITS > 32) ? PC_BITS : 32;
  localparam int KND_LO = PC_BITS;
  localparam int EXE_B  = PC_BITS + 2;
  localparam int MEM_B  = PC_BITS + 3;
  localparam int CNT_LO = PC_BITS + 4;
  localparam int SRC_LO = PC_BITS + 6;
  localparam int REC_W  = SRC_LO + MAX_SOURCES * PC_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_DEQ_WAIT, S_CHK_HEAD, S_SRC_START,
    S_SCAN_ISSUE, S_SCAN_CMP, S_PASS_ISSUE, S_PASS_CMP, S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [HW-1:0]    head_r [NUM_QUEUES];
  logic [HW-1:0]    head_nxt [NUM_QUEUES];
  logic [FW-1:0]    fill_r [NUM_QUEUES];
  logic [FW-1:0]    fill_nxt [NUM_QUEUES];
  logic [3:0]       exe_w_r, exe_w_nxt, mem_w_r, mem_w_nxt;
  logic             out_valid_r, out_valid_nxt;
  in_item_t         item_r, item_nxt;
  out_item_t        res_r, res_nxt;
  logic [REC_W-1:0] hold_r, hold_nxt;
  logic [FW-1:0]    k_r, k_nxt;
  logic [3:0]       done_r, done_nxt;
  logic [1:0]       src_idx_r, src_idx_nxt;
  logic             scan_mem_r, scan_mem_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;

  // shared slot address unit
  logic [2:0]       a_q;
  logic [FW-1:0]    a_k;
  logic [FW:0]      a_sum;
  logic [HW-1:0]    a_pos;
  logic [AW-1:0]    a_slot;

  // RAM port
  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [REC_W-1:0] ram_wdata, ram_rdata;

  // misc combinational
  logic [2:0]       q_sel;
  logic [FW-1:0]    fill_q, fill_scan, fill_pass;
  logic [1:0]       cnt_sat;
  logic [WB-1:0]    ext;
  logic [3:0]       wcap;
  logic [PC_BITS-1:0] cur_src, rd_pc;
  logic [1:0]       rd_kind;
  logic             blocked, mark_bit;

  psqs_ram #(.WIDTH(REC_W), .DEPTH(SLOTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // slot of the k-th entry of queue q
  always_comb begin
    a_sum = (FW + 1)'(head_r[a_q < 3'(NUM_QUEUES) ? a_q : 3'd0]) + (FW + 1)'(a_k);
    if (a_sum >= (FW + 1)'(QUEUE_DEPTH)) begin
      a_sum = a_sum - (FW + 1)'(QUEUE_DEPTH);
    end
    a_pos  = a_sum[HW-1:0];
    a_slot = AW'(a_q) * AW'(QUEUE_DEPTH) + AW'(a_pos);
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = res_r;
  assign cfg_ready = 1'b1;

  always_comb begin
    q_sel     = (item_r.stage < 3'(NUM_QUEUES)) ? item_r.stage : STG_FETCH;
    fill_q    = fill_r[q_sel];
    fill_scan = scan_mem_r ? fill_r[STG_MEMORY] : fill_r[STG_EXECUTE];
    fill_pass = (item_r.func == FUNC_MEMORY) ? fill_r[STG_MEMORY] : fill_r[STG_EXECUTE];
    cnt_sat   = (item_r.source_count > 2'(MAX_SOURCES)) ? 2'(MAX_SOURCES)
                                                        : item_r.source_count;
    wcap      = (item_r.func == FUNC_MEMORY) ? mem_w_r : exe_w_r;
    if (wcap > 4'(MARK_CAP)) begin
      wcap = 4'(MARK_CAP);
    end
    cur_src = '0;
    for (int i = 0; i < MAX_SOURCES; i++) begin
      if (src_idx_r == 2'(i)) begin
        cur_src = hold_r[SRC_LO + i * PC_BITS +: PC_BITS];
      end
    end
    rd_pc    = ram_rdata[PC_BITS-1:0];
    rd_kind  = ram_rdata[KND_LO +: 2];
    blocked  = (rd_pc == cur_src) &&
               (scan_mem_r ? ((rd_kind == KIND_LOAD || rd_kind == KIND_STORE) &&
                              !ram_rdata[MEM_B])
                           : !ram_rdata[EXE_B]);
    mark_bit = (item_r.func == FUNC_MEMORY) ? ram_rdata[MEM_B] : ram_rdata[EXE_B];
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    exe_w_nxt     = exe_w_r;
    mem_w_nxt     = mem_w_r;
    out_valid_nxt = out_valid_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    hold_nxt      = hold_r;
    k_nxt         = k_r;
    done_nxt      = done_r;
    src_idx_nxt   = src_idx_r;
    scan_mem_nxt  = scan_mem_r;
    addr_nxt      = addr_r;
    a_q           = q_sel;
    a_k           = '0;
    ext           = '0;
    ram_we        = 1'b0;
    ram_waddr     = addr_r;
    ram_wdata     = ram_rdata;
    ram_raddr     = a_slot;

    // take configuration writes
    if (cfg_valid) begin
      if (cfg_index == CFG_EXECUTE_WIDTH) begin
        exe_w_nxt = cfg_data;
      end else if (cfg_index == CFG_MEMORY_WIDTH) begin
        mem_w_nxt = cfg_data;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        res_nxt      = '0;
        k_nxt        = '0;
        done_nxt     = '0;
        src_idx_nxt  = '0;
        scan_mem_nxt = 1'b0;
        state_nxt    = S_DONE;
        case (item_r.func)
          FUNC_ENQUEUE: begin
            a_k = fill_q;
            if (item_r.stage >= 3'(NUM_QUEUES)) begin
              res_nxt.status = STATUS_OK;
            end else if (fill_q >= FW'(QUEUE_DEPTH)) begin
              res_nxt.status = STATUS_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = a_slot;
              ram_wdata = '0;
              ext = WB'(item_r.pc);
              ram_wdata[PC_BITS-1:0] = ext[PC_BITS-1:0];
              ram_wdata[KND_LO +: 2] = item_r.kind;
              ram_wdata[EXE_B]       = item_r.executed_in;
              ram_wdata[MEM_B]       = item_r.memorized_in;
              ram_wdata[CNT_LO +: 2] = cnt_sat;
              for (int i = 0; i < MAX_SOURCES; i++) begin
                case (i)
                  0:       ext = WB'(item_r.source_pc_a);
                  1:       ext = WB'(item_r.source_pc_b);
                  default: ext = WB'(item_r.source_pc_c);
                endcase
                ram_wdata[SRC_LO + i * PC_BITS +: PC_BITS] = ext[PC_BITS-1:0];
              end
              fill_nxt[q_sel] = fill_q + FW'(1);
            end
          end
          FUNC_DEQUEUE: begin
            if (item_r.stage >= 3'(NUM_QUEUES)) begin
              res_nxt.status = STATUS_OK;
            end else if (fill_q == '0) begin
              res_nxt.status = STATUS_EMPTY;
            end else begin
              head_nxt[q_sel] = (head_r[q_sel] == HW'(QUEUE_DEPTH - 1)) ? '0
                                : head_r[q_sel] + HW'(1);
              fill_nxt[q_sel] = fill_q - FW'(1);
              state_nxt       = S_DEQ_WAIT;
            end
          end
          FUNC_CHECK: begin
            a_q = STG_DECODE;
            if (fill_r[STG_DECODE] == '0) begin
              res_nxt.status = STATUS_EMPTY;
            end else begin
              state_nxt = S_CHK_HEAD;
            end
          end
          FUNC_EXECUTE, FUNC_MEMORY: begin
            state_nxt = S_PASS_ISSUE;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
        if (state_nxt == S_DONE) begin
          out_valid_nxt = 1'b1;
        end
      end

      S_DEQ_WAIT: begin
        ext = WB'(ram_rdata[PC_BITS-1:0]);
        res_nxt.out_pc           = ext[31:0];
        res_nxt.out_kind         = ram_rdata[KND_LO +: 2];
        res_nxt.out_executed     = ram_rdata[EXE_B];
        res_nxt.out_memorized    = ram_rdata[MEM_B];
        res_nxt.out_source_count = ram_rdata[CNT_LO +: 2];
        for (int i = 0; i < MAX_SOURCES; i++) begin
          ext = WB'(ram_rdata[SRC_LO + i * PC_BITS +: PC_BITS]);
          case (i)
            0:       res_nxt.out_source_a = ext[31:0];
            1:       res_nxt.out_source_b = ext[31:0];
            default: res_nxt.out_source_c = ext[31:0];
          endcase
        end
        out_valid_nxt = 1'b1;
        state_nxt     = S_DONE;
      end

      S_CHK_HEAD: begin
        hold_nxt  = ram_rdata;
        state_nxt = S_SRC_START;
      end

      S_SRC_START: begin
        if (src_idx_r >= hold_r[CNT_LO +: 2] || src_idx_r >= 2'(MAX_SOURCES)) begin
          res_nxt.ready_res = 1'b1;
          out_valid_nxt     = 1'b1;
          state_nxt         = S_DONE;
        end else begin
          scan_mem_nxt = 1'b0;
          k_nxt        = '0;
          state_nxt    = S_SCAN_ISSUE;
        end
      end

      S_SCAN_ISSUE: begin
        a_q = scan_mem_r ? STG_MEMORY : STG_EXECUTE;
        a_k = k_r;
        if (k_r >= fill_scan) begin
          k_nxt = '0;
          if (!scan_mem_r) begin
            scan_mem_nxt = 1'b1;
          end else begin
            src_idx_nxt = src_idx_r + 2'd1;
            state_nxt   = S_SRC_START;
          end
        end else begin
          state_nxt = S_SCAN_CMP;
        end
      end

      S_SCAN_CMP: begin
        if (blocked) begin
          res_nxt.ready_res = 1'b0;
          out_valid_nxt     = 1'b1;
          state_nxt         = S_DONE;
        end else begin
          k_nxt     = k_r + FW'(1);
          state_nxt = S_SCAN_ISSUE;
        end
      end

      S_PASS_ISSUE: begin
        a_q      = (item_r.func == FUNC_MEMORY) ? STG_MEMORY : STG_EXECUTE;
        a_k      = k_r;
        addr_nxt = a_slot;
        if (k_r >= fill_pass || done_r >= wcap) begin
          res_nxt.marked_count = done_r;
          out_valid_nxt        = 1'b1;
          state_nxt            = S_DONE;
        end else begin
          state_nxt = S_PASS_CMP;
        end
      end

      S_PASS_CMP: begin
        // set the mark of an unmarked entry and count it
        if (!mark_bit) begin
          ram_we = 1'b1;
          if (item_r.func == FUNC_MEMORY) begin
            ram_wdata[MEM_B] = 1'b1;
          end else begin
            ram_wdata[EXE_B] = 1'b1;
          end
          done_nxt = done_r + 4'd1;
        end
        k_nxt     = k_r + FW'(1);
        state_nxt = S_PASS_ISSUE;
      end

      S_DONE: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // hold state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      exe_w_r     <= 4'd1;
      mem_w_r     <= 4'd1;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_r[i] <= '0;
        fill_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      exe_w_r     <= exe_w_nxt;
      mem_w_r     <= mem_w_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
    end
  end

  // advance payload and working registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    res_r      <= res_nxt;
    hold_r     <= hold_nxt;
    k_r        <= k_nxt;
    done_r     <= done_nxt;
    src_idx_r  <= src_idx_nxt;
    scan_mem_r <= scan_mem_nxt;
    addr_r     <= addr_nxt;
  end

endmodule
